[rtl/bftr_pkg.sv]
// Shared types, constants and glyph ROM for the bitmap font text renderer.
package bftr_pkg;

  localparam int MaxSurfaceDim = 4096;
  localparam int GlyphCount    = 26;
  localparam int GlyphWidth    = 3;
  localparam int GlyphHeight   = 5;
  localparam int FirstCode     = 65;
  localparam int CellCount     = GlyphWidth * GlyphHeight;
  localparam int QueueDepth    = 2;

  localparam logic [13:0] ColumnMax = 14'h3FFF;

  typedef logic [12:0]          dim_t;
  typedef logic [CellCount-1:0] cell_mask_t;

  // One character after classification: which cells produce a pixel write,
  // where the glyph sits and what color it draws.
  typedef struct packed {
    cell_mask_t  mask;
    logic [11:0] base_x;
    logic [11:0] base_y;
    logic [31:0] ink;
  } bftr_desc_t;

  typedef struct packed {
    logic [2:0] row;
    logic [1:0] col;
  } cell_pos_t;

  // Each row is three cells; bit 2 is the leftmost.
  localparam logic [2:0] GLYPH_ROM [GlyphCount][GlyphHeight] = '{
    '{3'd2, 3'd5, 3'd7, 3'd5, 3'd5}, '{3'd6, 3'd5, 3'd6, 3'd5, 3'd6},
    '{3'd2, 3'd5, 3'd4, 3'd5, 3'd2}, '{3'd6, 3'd5, 3'd5, 3'd5, 3'd6},
    '{3'd7, 3'd4, 3'd6, 3'd4, 3'd7}, '{3'd7, 3'd4, 3'd6, 3'd4, 3'd4},
    '{3'd3, 3'd4, 3'd5, 3'd5, 3'd3}, '{3'd5, 3'd5, 3'd7, 3'd5, 3'd5},
    '{3'd2, 3'd2, 3'd2, 3'd2, 3'd2}, '{3'd1, 3'd1, 3'd1, 3'd5, 3'd2},
    '{3'd5, 3'd5, 3'd6, 3'd5, 3'd5}, '{3'd4, 3'd4, 3'd4, 3'd4, 3'd7},
    '{3'd5, 3'd7, 3'd5, 3'd5, 3'd5}, '{3'd5, 3'd5, 3'd7, 3'd7, 3'd5},
    '{3'd2, 3'd5, 3'd5, 3'd5, 3'd2}, '{3'd6, 3'd5, 3'd6, 3'd4, 3'd4},
    '{3'd2, 3'd5, 3'd5, 3'd7, 3'd3}, '{3'd6, 3'd5, 3'd6, 3'd5, 3'd5},
    '{3'd3, 3'd4, 3'd2, 3'd1, 3'd6}, '{3'd7, 3'd2, 3'd2, 3'd2, 3'd2},
    '{3'd5, 3'd5, 3'd5, 3'd5, 3'd2}, '{3'd5, 3'd5, 3'd5, 3'd2, 3'd2},
    '{3'd5, 3'd5, 3'd5, 3'd7, 3'd5}, '{3'd5, 3'd5, 3'd2, 3'd5, 3'd5},
    '{3'd5, 3'd5, 3'd2, 3'd2, 3'd2}, '{3'd7, 3'd1, 3'd2, 3'd4, 3'd7}
  };

  function automatic logic [2:0] glyph_row(logic [4:0] glyph, logic [2:0] row);
    logic [2:0] bits;
    bits = '0;
    if (int'(glyph) < GlyphCount && int'(row) < GlyphHeight) begin
      bits = GLYPH_ROM[glyph][row];
    end
    return bits;
  endfunction

  // Lowest set cell of the mask, scanning row by row, left to right.
  function automatic cell_pos_t first_cell(cell_mask_t mask);
    cell_pos_t pos;
    logic      found;
    pos   = '0;
    found = 1'b0;
    for (int r = 0; r < GlyphHeight; r++) begin
      for (int c = 0; c < GlyphWidth; c++) begin
        if (!found && mask[r*GlyphWidth + c]) begin
          found   = 1'b1;
          pos.row = 3'(r);
          pos.col = 2'(c);
        end
      end
    end
    return pos;
  endfunction

endpackage

[rtl/bftr_front.sv]
// Front end: accepts characters, tracks the text column, builds the cell mask.
module bftr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  bftr_pkg::dim_t     surface_width,
  input  bftr_pkg::dim_t     surface_height,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_start_of_text,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [7:0]         in_char_code,
  input  logic [31:0]        in_ink_color,
  output logic               q_push,
  output bftr_pkg::bftr_desc_t q_desc,
  input  logic               q_full
);
  import bftr_pkg::*;

  logic [13:0]        text_column_r;
  logic [13:0]        text_column_nxt;
  logic [13:0]        column;
  logic               accept;
  logic               is_letter;
  logic [7:0]         code_off;
  logic signed [17:0] base_x;
  logic [GlyphWidth-1:0]  col_ok;
  logic [GlyphHeight-1:0] row_ok;
  cell_mask_t         mask;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    logic signed [17:0] px;
    logic signed [16:0] py;
    logic [2:0]         rbits;
    column   = in_start_of_text ? '0 : text_column_r;
    code_off = in_char_code - 8'(FirstCode);
    is_letter = (in_char_code >= 8'(FirstCode)) && (code_off < 8'(GlyphCount));
    base_x   = $signed({{2{in_origin_x[15]}}, in_origin_x}) +
               $signed({2'b00, column, 2'b00});
    for (int c = 0; c < GlyphWidth; c++) begin
      px        = base_x + 18'(c);
      col_ok[c] = !px[17] && (px[16:0] < {4'b0, surface_width});
    end
    for (int r = 0; r < GlyphHeight; r++) begin
      py        = $signed({in_origin_y[15], in_origin_y}) + 17'(r);
      row_ok[r] = !py[16] && (py[15:0] < {3'b0, surface_height});
    end
    for (int r = 0; r < GlyphHeight; r++) begin
      rbits = glyph_row(code_off[4:0], 3'(r));
      for (int c = 0; c < GlyphWidth; c++) begin
        mask[r*GlyphWidth + c] = is_letter && row_ok[r] && col_ok[c] &&
                                 rbits[GlyphWidth-1-c];
      end
    end
    text_column_nxt = (column == ColumnMax) ? column : column + 14'd1;
  end

  // Drop characters that draw nothing; only visible work enters the queue.
  assign q_push        = accept && (|mask);
  assign q_desc.mask   = mask;
  assign q_desc.base_x = base_x[11:0];
  assign q_desc.base_y = in_origin_y[11:0];
  assign q_desc.ink    = in_ink_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_column_r <= '0;
    end else if (accept) begin
      text_column_r <= text_column_nxt;
    end
  end

endmodule

[rtl/bftr_queue.sv]
// Two-entry queue of classified characters between front and back end.
module bftr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bftr_pkg::bftr_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output bftr_pkg::bftr_desc_t head_desc,
  output logic                 head_valid
);
  import bftr_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  bftr_desc_t        entry_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [PtrW:0]     count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == (PtrW+1)'(QueueDepth));
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[rtl/bftr_back.sv]
// Back end: walks the mask one pixel per cycle unless stalled; forms writes.
module bftr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bftr_pkg::dim_t       surface_width,
  input  logic                 q_valid,
  input  bftr_pkg::bftr_desc_t q_desc,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [23:0]          out_pixel_address,
  output logic [11:0]          out_pixel_x,
  output logic [11:0]          out_pixel_y,
  output logic [31:0]          out_pixel_value,
  output logic                 out_last_pixel
);
  import bftr_pkg::*;

  // current character
  logic        cur_v_r;
  bftr_desc_t  cur_r;
  cell_mask_t  mask_rest;
  cell_pos_t   pos;
  logic        advance;
  logic        emit;
  logic        cur_done;
  logic        load;

  // select stage
  logic        s1_v_r;
  logic [11:0] s1_x_r;
  logic [11:0] s1_y_r;
  logic [31:0] s1_ink_r;
  logic        s1_last_r;

  // multiply stage
  logic        s2_v_r;
  logic [23:0] s2_prod_r;
  logic [11:0] s2_x_r;
  logic [11:0] s2_y_r;
  logic [31:0] s2_ink_r;
  logic        s2_last_r;
  logic [24:0] prod;

  // output register
  logic        out_v_r;
  logic [23:0] out_addr_r;
  logic [11:0] out_x_r;
  logic [11:0] out_y_r;
  logic [31:0] out_ink_r;
  logic        out_last_r;

  // The whole pipeline moves when the output register is free or being taken.
  assign advance   = !out_v_r || out_pop;
  assign pos       = first_cell(cur_r.mask);
  assign mask_rest = cur_r.mask & (cur_r.mask - 1'b1);
  assign emit      = cur_v_r && advance;
  assign cur_done  = emit && (mask_rest == '0);
  assign load      = (!cur_v_r || cur_done) && q_valid;
  assign q_pop     = load;
  assign prod      = {13'b0, s1_y_r} * {12'b0, surface_width};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        cur_v_r <= 1'b1;
      end else if (cur_done) begin
        cur_v_r <= 1'b0;
      end
      if (advance) begin
        s1_v_r  <= emit;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_desc;
    end else if (emit) begin
      cur_r.mask <= mask_rest;
    end
    if (advance) begin
      s1_x_r     <= cur_r.base_x + 12'(pos.col);
      s1_y_r     <= cur_r.base_y + 12'(pos.row);
      s1_ink_r   <= cur_r.ink;
      s1_last_r  <= (mask_rest == '0);
      s2_prod_r  <= prod[23:0];
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_ink_r   <= s1_ink_r;
      s2_last_r  <= s1_last_r;
      out_addr_r <= s2_prod_r + {12'b0, s2_x_r};
      out_x_r    <= s2_x_r;
      out_y_r    <= s2_y_r;
      out_ink_r  <= s2_ink_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_empty         = !out_v_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_x       = out_x_r;
  assign out_pixel_y       = out_y_r;
  assign out_pixel_value   = out_ink_r;
  assign out_last_pixel    = out_last_r;

endmodule

[rtl/bitmap_font_text_renderer_unit.sv]
// Top level of the bitmap font text renderer: configuration registers and wiring.
//
//   channel   direction  handshake         payload
//   in_*      input      in_push/in_full   start_of_text, origin x/y, char code, ink
//   out_*     output     out_pop/out_empty pixel address, x, y, value, last flag
//   APB       config     psel/penable      surface width (0x0), surface height (0x4)
//
// The front end takes one character per cycle while in_full is low; characters
// that draw nothing never enter the queue. The back end emits one pixel write
// per cycle unless stalled, one per visible lit cell (0 to 12) of a character,
// and each pixel passes the select, multiply and output registers in order.
// Reset sets the surface to 640 by 480 and the text column to zero.
// A low out_pop freezes the back end while a pixel is waiting; the two-entry queue
// lets the front keep taking characters until it fills, then in_full rises.
module bitmap_font_text_renderer_unit (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // character items
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_start_of_text,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [7:0]         in_char_code,
  input  logic [31:0]        in_ink_color,
  // pixel write items
  output logic               out_empty,
  input  logic               out_pop,
  output logic [23:0]        out_pixel_address,
  output logic [11:0]        out_pixel_x,
  output logic [11:0]        out_pixel_y,
  output logic [31:0]        out_pixel_value,
  output logic               out_last_pixel
);
  import bftr_pkg::*;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  dim_t       surface_width_r;
  dim_t       surface_height_r;
  dim_t       wr_value;
  logic       cfg_write;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  bftr_desc_t q_in_desc;
  bftr_desc_t q_head_desc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Clamp oversized dimensions to the largest surface supported.
  assign wr_value = (pwdata[12:0] > 13'(MaxSurfaceDim)) ? 13'(MaxSurfaceDim)
                                                        : pwdata[12:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_width_r  <= 13'd640;
      surface_height_r <= 13'd480;
    end else if (cfg_write) begin
      case (paddr[2])
        RegWidth:  surface_width_r  <= wr_value;
        RegHeight: surface_height_r <= wr_value;
        default:   surface_width_r  <= surface_width_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegWidth:  prdata = {19'b0, surface_width_r};
      RegHeight: prdata = {19'b0, surface_height_r};
      default:   prdata = '0;
    endcase
  end

  // Classify characters and build their visible cell masks.
  bftr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .surface_width    (surface_width_r),
    .surface_height   (surface_height_r),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_start_of_text (in_start_of_text),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_char_code     (in_char_code),
    .in_ink_color     (in_ink_color),
    .q_push           (q_push),
    .q_desc           (q_in_desc),
    .q_full           (q_full)
  );

  // Hold classified characters while the back end is busy.
  bftr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_in_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_desc  (q_head_desc),
    .head_valid (q_valid)
  );

  // Scan cells and produce pixel writes.
  bftr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .surface_width     (surface_width_r),
    .q_valid           (q_valid),
    .q_desc            (q_head_desc),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pixel_address (out_pixel_address),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_value   (out_pixel_value),
    .out_last_pixel    (out_last_pixel)
  );

endmodule

[test/tb.sv]
// Self-checking testbench for the bitmap font text renderer unit.

typedef struct packed {
  logic        sot;
  logic [15:0] ox;
  logic [15:0] oy;
  logic [7:0]  code;
  logic [31:0] ink;
} glyph_req_t;

typedef struct packed {
  logic [23:0] addr;
  logic [11:0] x;
  logic [11:0] y;
  logic [31:0] value;
  logic        last;
} pixel_wr_t;

localparam logic [2:0] SURF_WIDTH_ADDR  = 3'd0;
localparam logic [2:0] SURF_HEIGHT_ADDR = 3'd4;
localparam int         PixelsPerGlyph   = 12;

// Scoreboard: tracks the surface setup and text column, expands each
// accepted character into the pixel writes it must produce.
class pixel_board;
  pixel_wr_t   pending_px[$];
  logic [12:0] width_px;
  logic [12:0] height_px;
  logic [13:0] column;
  int          mismatches;

  function new();
    width_px   = 13'd640;
    height_px  = 13'd480;
    column     = '0;
    mismatches = 0;
  endfunction

  // Rows packed top first; bit 2 of each row is the leftmost cell.
  function logic [14:0] font_bits(int g);
    case (g)
      0:  return {3'd2, 3'd5, 3'd7, 3'd5, 3'd5};
      1:  return {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
      2:  return {3'd2, 3'd5, 3'd4, 3'd5, 3'd2};
      3:  return {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
      4:  return {3'd7, 3'd4, 3'd6, 3'd4, 3'd7};
      5:  return {3'd7, 3'd4, 3'd6, 3'd4, 3'd4};
      6:  return {3'd3, 3'd4, 3'd5, 3'd5, 3'd3};
      7:  return {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
      8:  return {3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
      9:  return {3'd1, 3'd1, 3'd1, 3'd5, 3'd2};
      10: return {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
      11: return {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
      12: return {3'd5, 3'd7, 3'd5, 3'd5, 3'd5};
      13: return {3'd5, 3'd5, 3'd7, 3'd7, 3'd5};
      14: return {3'd2, 3'd5, 3'd5, 3'd5, 3'd2};
      15: return {3'd6, 3'd5, 3'd6, 3'd4, 3'd4};
      16: return {3'd2, 3'd5, 3'd5, 3'd7, 3'd3};
      17: return {3'd6, 3'd5, 3'd6, 3'd5, 3'd5};
      18: return {3'd3, 3'd4, 3'd2, 3'd1, 3'd6};
      19: return {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
      20: return {3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
      21: return {3'd5, 3'd5, 3'd5, 3'd2, 3'd2};
      22: return {3'd5, 3'd5, 3'd5, 3'd7, 3'd5};
      23: return {3'd5, 3'd5, 3'd2, 3'd5, 3'd5};
      24: return {3'd5, 3'd5, 3'd2, 3'd2, 3'd2};
      25: return {3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
      default: return '0;
    endcase
  endfunction

  function void write_reg(logic [2:0] addr, logic [31:0] data);
    logic [12:0] v;
    v = data[12:0];
    if (v > 13'(bftr_pkg::MaxSurfaceDim)) v = 13'(bftr_pkg::MaxSurfaceDim);
    if (addr == SURF_WIDTH_ADDR) width_px = v;
    else if (addr == SURF_HEIGHT_ADDR) height_px = v;
  endfunction

  function int pending();
    return pending_px.size();
  endfunction

  function void note_char(glyph_req_t c);
    logic [13:0] col_now;
    logic [14:0] rows;
    int          bx, px, py, n, first;
    pixel_wr_t   p;
    col_now = c.sot ? 14'd0 : column;
    column  = (col_now == bftr_pkg::ColumnMax) ? col_now : col_now + 14'd1;
    if (int'(c.code) < bftr_pkg::FirstCode ||
        int'(c.code) >= bftr_pkg::FirstCode + bftr_pkg::GlyphCount) return;
    rows  = font_bits(int'(c.code) - bftr_pkg::FirstCode);
    bx    = int'($signed(c.ox)) + (bftr_pkg::GlyphWidth + 1) * int'(col_now);
    n     = 0;
    first = pending_px.size();
    for (int r = 0; r < bftr_pkg::GlyphHeight; r++) begin
      py = int'($signed(c.oy)) + r;
      if (py < 0 || py >= int'(height_px)) continue;
      for (int k = 0; k < bftr_pkg::GlyphWidth; k++) begin
        px = bx + k;
        if (px < 0 || px >= int'(width_px)) continue;
        if (!rows[14 - 3*r - k] || n >= PixelsPerGlyph) continue;
        p.addr  = 24'(py * int'(width_px) + px);
        p.x     = 12'(px);
        p.y     = 12'(py);
        p.value = c.ink;
        p.last  = 1'b0;
        pending_px.push_back(p);
        n++;
      end
    end
    if (n > 0) pending_px[first + n - 1].last = 1'b1;
  endfunction

  function void report(string what, pixel_wr_t want, pixel_wr_t got);
    string want_s;
    string got_s;
    mismatches++;
    if (mismatches <= 10) begin
      want_s = $sformatf("addr=%0d x=%0d y=%0d value=%h last=%b",
                         want.addr, want.x, want.y, want.value, want.last);
      got_s  = $sformatf("addr=%0d x=%0d y=%0d value=%h last=%b",
                         got.addr, got.x, got.y, got.value, got.last);
      $display("%s: expected %s, got %s", what, want_s, got_s);
    end
  endfunction

  function void check_pixel(pixel_wr_t got);
    pixel_wr_t want;
    if (pending_px.size() == 0) begin
      report("unexpected pixel write", '0, got);
      return;
    end
    want = pending_px.pop_front();
    if (got.addr !== want.addr || got.x !== want.x || got.y !== want.y ||
        got.value !== want.value || got.last !== want.last)
      report("pixel write mismatch", want, got);
  endfunction

  function void flush_leftover();
    while (pending_px.size() > 0) report("missing pixel write", pending_px.pop_front(), '0);
  endfunction
endclass

module tb;
  import bftr_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 20;
  localparam int HoldCycles  = 400;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_push;
  logic               in_full;
  logic               in_start_of_text;
  logic signed [15:0] in_origin_x;
  logic signed [15:0] in_origin_y;
  logic [7:0]         in_char_code;
  logic [31:0]        in_ink_color;
  logic               out_empty;
  logic               out_pop;
  logic [23:0]        out_pixel_address;
  logic [11:0]        out_pixel_x;
  logic [11:0]        out_pixel_y;
  logic [31:0]        out_pixel_value;
  logic               out_last_pixel;

  pixel_board sb;
  bit         no_idle;
  bit         hold_req;
  int         hold_cnt;
  int         text_left;
  int         org_x;
  int         org_y;

  bitmap_font_text_renderer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_start_of_text (in_start_of_text),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_char_code     (in_char_code),
    .in_ink_color     (in_ink_color),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_address(out_pixel_address),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_value  (out_pixel_value),
    .out_last_pixel   (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Pixel receiver: sample at the rising edge, decide pop at the falling edge.
  // A requested hold-off drops pop until hold_cnt runs down, so the block
  // backs up and raises in_full.
  initial begin
    pixel_wr_t got;
    out_pop  = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got.addr  = out_pixel_address;
        got.x     = out_pixel_x;
        got.y     = out_pixel_y;
        got.value = out_pixel_value;
        got.last  = out_last_pixel;
        sb.check_pixel(got);
      end
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HoldCycles;
        out_pop <= 1'b0;
      end else begin
        out_pop <= no_idle || ($urandom_range(99) >= 10);
      end
    end
  end

  function automatic logic [7:0] non_letter();
    logic [7:0] v;
    do v = 8'($urandom);
    while (int'(v) >= FirstCode && int'(v) < FirstCode + GlyphCount);
    return v;
  endfunction

  function automatic glyph_req_t mk_char(logic sot, int ox, int oy, logic [7:0] code,
                                         logic [31:0] ink);
    glyph_req_t c;
    c.sot  = sot;
    c.ox   = 16'(ox);
    c.oy   = 16'(oy);
    c.code = code;
    c.ink  = ink;
    return c;
  endfunction

  // Mostly well-formed texts placed around the surface, some pure noise.
  function automatic glyph_req_t next_text_char();
    glyph_req_t c;
    int         w, h;
    w = int'(sb.width_px);
    h = int'(sb.height_px);
    if ($urandom_range(99) < 15) begin
      c.sot  = 1'($urandom);
      c.ox   = 16'($urandom);
      c.oy   = 16'($urandom);
      c.code = 8'($urandom);
      c.ink  = $urandom;
      return c;
    end
    if (text_left == 0) begin
      text_left = $urandom_range(8, 1);
      org_x     = int'($urandom_range(w + 4)) - 6;
      org_y     = int'($urandom_range(h + 4)) - 6;
      c.sot     = 1'b1;
    end else begin
      c.sot = 1'b0;
    end
    text_left--;
    c.ox   = 16'(org_x);
    c.oy   = 16'(org_y);
    c.code = ($urandom_range(9) == 0) ? non_letter()
                                      : 8'(FirstCode + $urandom_range(GlyphCount - 1));
    c.ink  = $urandom;
    return c;
  endfunction

  // Offer one character; hold it until the block takes it.
  task automatic send_char(input glyph_req_t c);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push          <= 1'b1;
    in_start_of_text <= c.sot;
    in_origin_x      <= c.ox;
    in_origin_y      <= c.oy;
    in_char_code     <= c.code;
    in_ink_color     <= c.ink;
    do @(posedge clk); while (in_full);
    sb.note_char(c);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop push, wait out every expected pixel, then let silent items settle.
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_surface(input logic [31:0] w, input logic [31:0] h);
    drain();
    cfg_write(SURF_WIDTH_ADDR, w);
    cfg_write(SURF_HEIGHT_ADDR, h);
  endtask

  initial begin
    logic [31:0] phase_w [7];
    logic [31:0] phase_h [7];
    sb               = new();
    no_idle          = 1'b0;
    hold_req         = 1'b0;
    text_left        = 0;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_push          = 1'b0;
    in_start_of_text = 1'b0;
    in_origin_x      = '0;
    in_origin_y      = '0;
    in_char_code     = '0;
    in_ink_color     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset surface 640x480; first item uses the reset column without a start flag.
    send_char(mk_char(1'b0, 0, 0, 8'd65, 32'hFFFF_FFFF));
    send_char(mk_char(1'b0, 0, 0, 8'd66, 32'h0000_0000));
    send_char(mk_char(1'b0, 0, 0, 8'd64, $urandom));   // just below 'A': column still moves
    send_char(mk_char(1'b0, 0, 0, 8'd90, $urandom));
    send_char(mk_char(1'b0, 0, 0, 8'd91, $urandom));
    send_char(mk_char(1'b0, 0, 0, 8'd0, $urandom));
    send_char(mk_char(1'b0, 0, 0, 8'd255, $urandom));
    // Partial clipping on every edge, and glyphs far off the surface.
    send_char(mk_char(1'b1, -1, -2, 8'd77, $urandom));
    send_char(mk_char(1'b1, 638, 477, 8'd87, $urandom));
    send_char(mk_char(1'b1, -32768, -32768, 8'd81, $urandom));
    send_char(mk_char(1'b1, 32767, 32767, 8'd78, $urandom));
    send_char(mk_char(1'b1, -32768, 10, 8'd69, $urandom));

    // Largest surface: draw in the far corner.
    set_surface(32'd4096, 32'd4096);
    send_char(mk_char(1'b1, 4093, 4091, 8'd72, $urandom));
    send_char(mk_char(1'b0, 4093, 4091, 8'd75, $urandom));

    // One-pixel surface.
    set_surface(32'd1, 32'd1);
    send_char(mk_char(1'b1, -1, 0, 8'd65, $urandom));
    send_char(mk_char(1'b1, -1, 0, 8'd73, $urandom));

    // Zero width clips everything.
    set_surface(32'd0, 32'd480);
    send_char(mk_char(1'b1, 0, 0, 8'd79, $urandom));

    // Oversized writes saturate to the maximum dimension; upper data bits ignored.
    set_surface(32'd8191, 32'hFFFF_FFFF);
    send_char(mk_char(1'b1, 0, 0, 8'd88, $urandom));
    send_char(mk_char(1'b1, 100, 4092, 8'd89, $urandom));

    // Random phases over several surface settings.
    phase_w = '{32'd640, 32'd16, 32'd4096, 32'd1, 32'd4096, 32'd0, 32'd0};
    phase_h = '{32'd480, 32'd8, 32'd4096, 32'd4096, 32'd1, 32'd0, 32'd0};
    phase_w[5] = $urandom_range(4096, 1);
    phase_h[5] = $urandom_range(4096, 1);
    phase_w[6] = $urandom;
    phase_h[6] = $urandom;
    for (int p = 0; p < 7; p++) begin
      set_surface(phase_w[p], phase_h[p]);
      text_left = 0;
      hold_req  = (p == 1);   // back the block up on the small surface
      no_idle   = (p == 2);   // full-rate stretch on both sides
      for (int i = 0; i < 50; i++) send_char(next_text_char());
      drain();
      no_idle = 1'b0;
    end

    sb.flush_leftover();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bftr_pkg.sv
rtl/bftr_front.sv
rtl/bftr_queue.sv
rtl/bftr_back.sv
rtl/bitmap_font_text_renderer_unit.sv
test/tb.sv
